// ===== hw/rtl/pospo2_pkg.sv =====
// ----------------------------------------------------------------------------
// pospo2_pkg: shared types and constants of the pulse / SpO2 estimator
// Field widths, transfer payload structs and the SpO2 line coefficients.
// ----------------------------------------------------------------------------
package pospo2_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 16;
  localparam int DC_W     = 16;
  localparam int CONST_W  = 20;
  localparam int BPM_W    = 20;
  localparam int SPO2_W   = 7;

  // ratio of ratios, fixed point
  localparam int FRAC_W   = 8;
  localparam int PROD_W   = SAMPLE_W + DC_W;
  localparam int NUM_W    = PROD_W + FRAC_W;
  localparam int SUM_W    = COUNT_W + 1;

  // saturated ratio: anything above 120*256/35 already gives zero saturation
  localparam int R8_W     = 10;

  // serial step counts
  localparam int MUL_STEPS = DC_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int PDIV_STEPS = CONST_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // spo2 lines: 110 - 25 r below r = 1, 120 - 35 r above
  localparam int V_W       = 17;
  localparam int ONE_R8    = 1 << FRAC_W;
  localparam int LO_BASE   = 110 * ONE_R8;
  localparam int LO_SLOPE  = 25;
  localparam int HI_BASE   = 120 * ONE_R8;
  localparam int HI_SLOPE  = 35;
  localparam int SPO2_MAX  = 110;

  localparam logic [CONST_W-1:0] PULSE_CONST_RST = CONST_W'(60000);

  // input transfer payload
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] red_ac;
    logic signed [SAMPLE_W-1:0] ir_ac;
    logic        [DC_W-1:0]     red_dc;
    logic        [DC_W-1:0]     ir_dc;
  } in_item_t;

  // result transfer payload
  typedef struct packed {
    logic [BPM_W-1:0]  pulse_bpm;
    logic [SPO2_W-1:0] spo2_percent;
    logic              spo2_valid;
  } out_item_t;

  // per-channel crossing and extreme tracking state
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] prev;
    logic signed [SAMPLE_W-1:0] mx;
    logic signed [SAMPLE_W-1:0] mn;
    logic        [COUNT_W-1:0]  run;
    logic        [COUNT_W-1:0]  period;
  } chan_t;

endpackage

// ===== hw/rtl/pulse_oximeter_spo2_pulse_top.sv =====
// ----------------------------------------------------------------------------
// pulse_oximeter_spo2_pulse_top: pulse rate and SpO2 from red / infrared samples
// Zero-crossing period tracking, peak-to-peak ratio of ratios, bit-serial
// multiply and divide.
// ----------------------------------------------------------------------------
// channel   signals                         payload
// in        in_valid / in_ready             in_data   (in_item_t)
// out       out_valid / out_ready           out_data  (out_item_t)
// cfg       cfg_valid / cfg_ready           cfg_data  (pulse constant, 20 bits)
//
// An input transfer updates the channel trackers in its own cycle, then two
// shift-add multipliers step through the 16-bit DC operands and the restoring
// dividers through the 40-bit ratio numerator (one quotient bit a cycle; the pulse
// divider ends after its 20-bit constant). S_DONE then forms SpO2 and loads the
// output register, waiting while that register still holds an unaccepted result,
// and the input stays not ready until the receiver takes it.
// Reset (synchronous, rst_n low) clears all tracking state and sets the pulse
// constant to 60000.
module pulse_oximeter_spo2_pulse_top
  import pospo2_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CONST_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [CNT_W-1:0]   MUL_LAST  = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0]   PDIV_END  = CNT_W'(PDIV_STEPS);
  localparam logic [R8_W-1:0]    R8_SAT    = {R8_W{1'b1}};

  // crossing clears, period latch, saturating count, then extremes
  function automatic chan_t chan_next(input chan_t c,
                                      input logic signed [SAMPLE_W-1:0] x);
    chan_t n;
    n = c;
    if (!c.prev[SAMPLE_W-1] && x[SAMPLE_W-1]) n.mn = '0;
    if (!x[SAMPLE_W-1] && c.prev[SAMPLE_W-1]) begin
      n.mx     = '0;
      n.period = c.run;
      n.run    = '0;
    end
    if (n.run != COUNT_MAX) n.run = n.run + 1'b1;
    n.prev = x;
    if (n.mx < x) n.mx = x;
    if (n.mn > x) n.mn = x;
    return n;
  endfunction

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    step_r;
  logic [CONST_W-1:0]  pulse_const_r;
  chan_t               red_r, ir_r;
  chan_t               red_nxt, ir_nxt;

  // per-item datapath registers
  logic                pulse_ok_r;
  logic                spo2_ok_r;
  logic [PROD_W-1:0]   mcand_num_r, mcand_den_r;
  logic [DC_W-1:0]     mplier_num_r, mplier_den_r;
  logic [PROD_W-1:0]   acc_num_r, acc_den_r;
  logic [NUM_W-1:0]    num_sr_r;
  logic [PROD_W-1:0]   rem_r;
  logic [R8_W-1:0]     q_r;
  logic                ovf_r;
  logic [CONST_W-1:0]  pnum_sr_r;
  logic [SUM_W-1:0]    psum_r;
  logic [SUM_W-1:0]    prem_r;
  logic [CONST_W-1:0]  pq_r;

  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r;

  logic                in_xfer;
  logic                load_out;
  logic [SAMPLE_W-1:0] red_ptp, ir_ptp;
  logic [SUM_W-1:0]    sum_nxt;
  logic                pulse_ok_nxt, spo2_ok_nxt;

  logic [PROD_W:0]     rem_sh;
  logic                q_bit;
  logic [PROD_W-1:0]   rem_nxt;
  logic [SUM_W:0]      prem_sh;
  logic                pq_bit;
  logic [SUM_W-1:0]    prem_nxt;

  logic [R8_W-1:0]     r8;
  logic [V_W-1:0]      lo_val, hi_prod, hi_val;
  logic [V_W-FRAC_W-1:0] spo2_wide;
  logic [SPO2_W-1:0]   spo2_nxt;
  out_item_t           out_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // tracker update and per-item flags
  always_comb begin
    red_nxt      = chan_next(red_r, in_data.red_ac);
    ir_nxt       = chan_next(ir_r, in_data.ir_ac);
    red_ptp      = SAMPLE_W'(red_nxt.mx - red_nxt.mn);
    ir_ptp       = SAMPLE_W'(ir_nxt.mx - ir_nxt.mn);
    sum_nxt      = SUM_W'(red_nxt.period) + SUM_W'(ir_nxt.period);
    pulse_ok_nxt = ((red_nxt.period != red_nxt.run) || (ir_nxt.period != ir_nxt.run))
                   && (sum_nxt != '0);
    spo2_ok_nxt  = (in_data.red_dc != '0) && (in_data.ir_dc != '0) && (ir_ptp != '0);
  end

  // ratio divider step, one quotient bit
  always_comb begin
    rem_sh  = {rem_r, num_sr_r[NUM_W-1]};
    q_bit   = (rem_sh >= {1'b0, acc_den_r});
    rem_nxt = q_bit ? PROD_W'(rem_sh - {1'b0, acc_den_r}) : rem_sh[PROD_W-1:0];
  end

  // pulse divider step, one quotient bit
  always_comb begin
    prem_sh  = {prem_r, pnum_sr_r[CONST_W-1]};
    pq_bit   = (prem_sh >= {1'b0, psum_r});
    prem_nxt = pq_bit ? SUM_W'(prem_sh - {1'b0, psum_r}) : prem_sh[SUM_W-1:0];
  end

  // spo2 from the saturated ratio
  always_comb begin
    r8        = ovf_r ? R8_SAT : q_r;
    lo_val    = V_W'(LO_BASE) - V_W'(r8) * V_W'(LO_SLOPE);
    hi_prod   = V_W'(r8) * V_W'(HI_SLOPE);
    hi_val    = V_W'(HI_BASE) - hi_prod;
    if (V_W'(r8) <= V_W'(ONE_R8)) begin
      spo2_wide = lo_val[V_W-1:FRAC_W];
    end else if (hi_prod >= V_W'(HI_BASE)) begin
      spo2_wide = '0;
    end else begin
      spo2_wide = hi_val[V_W-1:FRAC_W];
    end
    if (spo2_wide > (V_W-FRAC_W)'(SPO2_MAX)) spo2_nxt = SPO2_W'(SPO2_MAX);
    else spo2_nxt = spo2_wide[SPO2_W-1:0];
    out_nxt.pulse_bpm    = pulse_ok_r ? pq_r : '0;
    out_nxt.spo2_percent = spo2_ok_r ? spo2_nxt : '0;
    out_nxt.spo2_valid   = spo2_ok_r;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_MUL;
      S_MUL:  if (step_r == MUL_LAST) state_nxt = S_DIV;
      S_DIV:  if (step_r == DIV_LAST) state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      step_r        <= '0;
      out_valid_r   <= 1'b0;
      pulse_const_r <= PULSE_CONST_RST;
      red_r         <= '0;
      ir_r          <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) pulse_const_r <= cfg_data;
      if (in_xfer) begin
        red_r <= red_nxt;
        ir_r  <= ir_nxt;
      end
      if (state_r != state_nxt) step_r <= '0;
      else step_r <= step_r + 1'b1;
    end
  end

  // serial datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          pulse_ok_r   <= pulse_ok_nxt;
          spo2_ok_r    <= spo2_ok_nxt;
          mcand_num_r  <= PROD_W'(red_ptp);
          mplier_num_r <= in_data.ir_dc;
          mcand_den_r  <= PROD_W'(ir_ptp);
          mplier_den_r <= in_data.red_dc;
          acc_num_r    <= '0;
          acc_den_r    <= '0;
          rem_r        <= '0;
          q_r          <= '0;
          ovf_r        <= 1'b0;
          pnum_sr_r    <= pulse_const_r;
          psum_r       <= sum_nxt;
          prem_r       <= '0;
          pq_r         <= '0;
        end
      end
      S_MUL: begin
        if (mplier_num_r[0]) acc_num_r <= acc_num_r + mcand_num_r;
        if (mplier_den_r[0]) acc_den_r <= acc_den_r + mcand_den_r;
        mcand_num_r  <= mcand_num_r << 1;
        mcand_den_r  <= mcand_den_r << 1;
        mplier_num_r <= mplier_num_r >> 1;
        mplier_den_r <= mplier_den_r >> 1;
        if (step_r == MUL_LAST) begin
          num_sr_r <= {(mplier_num_r[0] ? acc_num_r + mcand_num_r : acc_num_r),
                       {FRAC_W{1'b0}}};
        end
      end
      S_DIV: begin
        rem_r    <= rem_nxt;
        q_r      <= {q_r[R8_W-2:0], q_bit};
        ovf_r    <= ovf_r | q_r[R8_W-1];
        num_sr_r <= num_sr_r << 1;
        if (step_r < PDIV_END) begin
          prem_r    <= prem_nxt;
          pq_r      <= {pq_r[CONST_W-2:0], pq_bit};
          pnum_sr_r <= pnum_sr_r << 1;
        end
      end
      S_DONE: begin
        if (load_out) out_data_r <= out_nxt;
      end
      default: ;
    endcase
  end

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_MUL)
    else $error("accepted item did not start the multiply phase");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && step_r == DIV_LAST) |=> state_r == S_DONE)
    else $error("divide phase ran past its last step");

  a_spo2_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.spo2_percent <= SPO2_W'(SPO2_MAX))
    else $error("spo2 above clamp");

  a_spo2_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.spo2_valid) |-> out_data_r.spo2_percent == '0)
    else $error("invalid spo2 not forced to zero");

endmodule
